@@ src/mvt_pkg.sv @@
// shared types and constants of the 4x4 matrix-vector transform engine
package mvt_pkg;

  localparam int unsigned DIM = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned RND_W = SUM_W - FRAC_W;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W - 1) {1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W - 1) {1'b0}}};

  // classified command: for a load, comp[0] carries the element value
  typedef struct packed {
    logic                          is_xform;
    logic [ADDR_W-1:0]             addr;
    logic [DIM-1:0][DATA_W-1:0]    comp;
  } cmd_t;

  typedef struct packed {
    logic [DIM-1:0][DATA_W-1:0] value;
    logic                       saturated;
  } res_t;

  // handshake between command queue and back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

@@ src/mvt_front.sv @@
// front end: classifies incoming items and holds them in the command queue
module mvt_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     opcode,
  input  logic [1:0]               row_index,
  input  logic [1:0]               col_index,
  input  logic signed [31:0]       element_value,
  input  logic signed [31:0]       vec_x,
  input  logic signed [31:0]       vec_y,
  input  logic signed [31:0]       vec_z,
  input  logic signed [31:0]       vec_w,
  output mvt_pkg::cmd_head_t       head,
  input  logic                     head_pop
);
  import mvt_pkg::*;

  cmd_t                 entry [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  cmd_t                 classified;
  logic                 do_push;
  logic                 do_pop;

  always_comb begin
    classified = '0;
    unique case (opcode)
      OP_LOAD: begin
        classified.is_xform = 1'b0;
        classified.addr = {row_index, col_index};
        classified.comp[0] = element_value;
      end
      OP_TRANSFORM: begin
        classified.is_xform = 1'b1;
        classified.comp[0] = vec_x;
        classified.comp[1] = vec_y;
        classified.comp[2] = vec_z;
        classified.comp[3] = vec_w;
      end
      default: classified = '0;
    endcase
  end

  assign full = (count == CMD_CNT_W'(CMD_DEPTH));
  assign do_push = push && !full;
  assign do_pop = head_pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.cmd = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10: count <= count + CMD_CNT_W'(1);
        2'b01: count <= count - CMD_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/mvt_back.sv @@
// back end: matrix storage and the multiply, add and round pipeline
module mvt_back (
  input  logic                              clk,
  input  logic                              rst,
  input  mvt_pkg::cmd_head_t                head,
  output logic                              head_pop,
  input  logic [mvt_pkg::RES_CNT_W-1:0]     res_count,
  output logic                              res_valid,
  output mvt_pkg::res_t                     res_data
);
  import mvt_pkg::*;

  logic signed [DATA_W-1:0] matrix [DIM][DIM];

  logic                     s1_valid;
  logic signed [PROD_W-1:0] s1_prod [DIM][DIM];
  logic                     s2_valid;
  logic signed [PAIR_W-1:0] s2_lo [DIM];
  logic signed [PAIR_W-1:0] s2_hi [DIM];
  logic                     s3_valid;
  res_t                     s3_res;
  res_t                     s3_res_next;

  logic [1:0]               inflight;
  logic [RES_CNT_W:0]       committed;
  logic                     credit;
  logic                     issue_load;
  logic                     issue_xform;

  // every transform in flight already owns a result queue slot
  assign inflight = 2'(s1_valid) + 2'(s2_valid) + 2'(s3_valid);
  assign committed = (RES_CNT_W + 1)'(res_count) + (RES_CNT_W + 1)'(inflight);
  assign credit = committed < (RES_CNT_W + 1)'(RES_DEPTH);
  assign issue_load = head.valid && !head.cmd.is_xform;
  assign issue_xform = head.valid && head.cmd.is_xform && credit;
  assign head_pop = issue_load || issue_xform;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          matrix[r][c] <= '0;
        end
      end
    end else if (issue_load) begin
      matrix[head.cmd.addr[3:2]][head.cmd.addr[1:0]] <= head.cmd.comp[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue_xform;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        s1_prod[r][c] <= matrix[r][c] * $signed(head.cmd.comp[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < DIM; r++) begin
      s2_lo[r] <= s1_prod[r][0] + s1_prod[r][1];
      s2_hi[r] <= s1_prod[r][2] + s1_prod[r][3];
    end
  end

  // final add, round half up, saturate
  always_comb begin
    logic signed [SUM_W-1:0]  total;
    logic signed [RND_W-1:0]  rnd;
    logic [RND_W-DATA_W:0]    top;
    s3_res_next = '0;
    for (int r = 0; r < DIM; r++) begin
      total = s2_lo[r] + s2_hi[r] + ROUND_HALF;
      rnd = total[SUM_W-1:FRAC_W];
      top = rnd[RND_W-1:DATA_W-1];
      if (!rnd[RND_W-1] && (|top)) begin
        s3_res_next.value[r] = SAT_MAX;
        s3_res_next.saturated = 1'b1;
      end else if (rnd[RND_W-1] && !(&top)) begin
        s3_res_next.value[r] = SAT_MIN;
        s3_res_next.saturated = 1'b1;
      end else begin
        s3_res_next.value[r] = rnd[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_res <= s3_res_next;
  end

  assign res_valid = s3_valid;
  assign res_data = s3_res;

endmodule

@@ src/mvt_res_queue.sv @@
// result queue between the back end and the output ports
module mvt_res_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_valid,
  input  mvt_pkg::res_t                 wr_data,
  output logic [mvt_pkg::RES_CNT_W-1:0] count,
  output logic                          empty,
  input  logic                          pop,
  output mvt_pkg::res_t                 head
);
  import mvt_pkg::*;

  res_t                 entry [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic                 do_pop;

  assign empty = (count == '0);
  assign do_pop = pop && !empty;
  assign head = entry[rd_ptr];

  // the back end never writes without a free slot
  always_ff @(posedge clk) begin
    if (wr_valid) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= wr_ptr + RES_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      case ({wr_valid, do_pop})
        2'b10: count <= count + RES_CNT_W'(1);
        2'b01: count <= count - RES_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/mat4_vec4_transform.sv @@
// top level of the 4x4 matrix-vector transform engine
// usage
//   input side is a queue: an item enters on a clock edge with push high and full low
//   opcode 0 loads element_value into row_index/col_index and yields no result
//   opcode 1 transforms (vec_x, vec_y, vec_z, vec_w) and yields one result item
//   result side is a queue: while empty is low the oldest result sits on
//   out_0..out_3 and saturated, and pop with empty low takes it
// throughput and result path
//   one item per cycle sustained while results are popped, loads and transforms mixed freely
//   a transform passes in order through the command queue, the multiply stage, the
//   pair add stage and the final add/round/saturate stage, which ends with the
//   result queue write
//   a load takes effect for every transform accepted after it
// reset
//   rst is synchronous; it clears the matrix to zero and empties both queues
// stalls
//   the back end only issues a transform when a result queue slot is reserved
//   for it, so a stalled receiver first fills the result queue (8 items),
//   then the 4-item command queue, and then full rises; nothing is dropped
module mat4_vec4_transform (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [1:0]         row_index,
  input  logic [1:0]         col_index,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [31:0] vec_w,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_0,
  output logic signed [31:0] out_1,
  output logic signed [31:0] out_2,
  output logic signed [31:0] out_3,
  output logic               saturated
);
  import mvt_pkg::*;

  // front to back
  cmd_head_t            head;
  logic                 head_pop;

  // back to result queue
  logic                 res_valid;
  res_t                 res_data;
  logic [RES_CNT_W-1:0] res_count;
  res_t                 res_head;

  mvt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .opcode        (opcode),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .vec_x         (vec_x),
    .vec_y         (vec_y),
    .vec_z         (vec_z),
    .vec_w         (vec_w),
    .head          (head),
    .head_pop      (head_pop)
  );

  mvt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_pop  (head_pop),
    .res_count (res_count),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  mvt_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (res_valid),
    .wr_data  (res_data),
    .count    (res_count),
    .empty    (empty),
    .pop      (pop),
    .head     (res_head)
  );

  // unpack the head result onto the output ports
  assign out_0 = res_head.value[0];
  assign out_1 = res_head.value[1];
  assign out_2 = res_head.value[2];
  assign out_3 = res_head.value[3];
  assign saturated = res_head.saturated;

endmodule
